>>> src/debounced_key_event_queue_core_assert.svh
// Assertion macros for the key event queue.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
// The assertion is switched off while the active-low reset is asserted.
`ifndef DEBOUNCED_KEY_EVENT_QUEUE_CORE_ASSERT_SVH
`define DEBOUNCED_KEY_EVENT_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DKEQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dkeq_pkg.sv
package dkeq_pkg;

    // Default ring depth; the ring keeps at most one entry fewer than this.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int DEB_W  = 10;
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 48;
    localparam int LED_W  = 8;

    // The debounce register comes out of reset at this value.
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(20);

    // Operation codes.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_READ    = 2'd1,
        OP_SET_LED = 2'd2,
        OP_GET_LED = 2'd3
    } t_opcode;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_LED = 2'd2;

    // One stored key record.
    typedef struct packed {
        logic              level;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } t_rec;

    // One result item.
    typedef struct packed {
        logic [1:0]        status;
        logic              nonempty;
        logic              event_pushed;
        logic              rec_level;
        logic [SEQ_W-1:0]  rec_sequence;
        logic [TIME_W-1:0] rec_time;
        logic              led_level;
    } t_rsp;

endpackage

>>> src/dkeq_if.sv
// Request channel: one operation per item.
interface dkeq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       key_level;
    logic [dkeq_pkg::LED_W-1:0] led_request;

    modport source (output valid, output opcode, output key_level, output led_request,
                    input ready);
    modport sink   (input valid, input opcode, input key_level, input led_request,
                    output ready);
endinterface

// Response channel: one result item per request.
interface dkeq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       nonempty;
    logic       event_pushed;
    logic       rec_level;
    logic [dkeq_pkg::SEQ_W-1:0]  rec_sequence;
    logic [dkeq_pkg::TIME_W-1:0] rec_time;
    logic       led_level;

    modport source (output valid, output status, output nonempty, output event_pushed,
                    output rec_level, output rec_sequence, output rec_time,
                    output led_level, input ready);
    modport sink   (input valid, input status, input nonempty, input event_pushed,
                    input rec_level, input rec_sequence, input rec_time,
                    input led_level, output ready);
endinterface

// Configuration write channel for the debounce register.
interface dkeq_cfg_if;
    logic valid;
    logic ready;
    logic [dkeq_pkg::DEB_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/dkeq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module dkeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/debounced_key_event_queue_core.sv
// Tick, LED and empty-read items give their result item in the cycle after acceptance;
// a read that returns a record passes the ring RAM's registered read port, then the output register.
// One tick or LED item per cycle while the output is free; no item is taken during a ring read.
// Reset is synchronous and active low; it clears the counters, indices, debounce and LED state.
// The ring RAM is not cleared: only written entries are ever read, so no clearing pass runs.
`include "debounced_key_event_queue_core_assert.svh"

module debounced_key_event_queue_core #(
    parameter int QUEUE_DEPTH = dkeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dkeq_req_if.sink   i_req,
    dkeq_rsp_if.source o_rsp,
    dkeq_cfg_if.sink   i_cfg
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam int REC_W = $bits(dkeq_pkg::t_rec);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    t_state                         r_state, n_state;
    logic [dkeq_pkg::DEB_W-1:0]     r_deb_cfg;
    logic [dkeq_pkg::TIME_W-1:0]    r_clock, n_clock;
    logic                           r_last_raw, n_last_raw;
    logic [dkeq_pkg::DEB_W-1:0]     r_left, n_left;
    logic                           r_armed, n_armed;
    logic [IW-1:0]                  r_wr_idx, n_wr_idx;
    logic [IW-1:0]                  r_rd_idx, n_rd_idx;
    logic [dkeq_pkg::SEQ_W-1:0]     r_seq, n_seq;
    logic                           r_led, n_led;
    dkeq_pkg::t_rsp                 r_out, n_out;
    logic                           r_out_valid, n_out_valid;

    logic           out_free;
    logic           accept;
    logic           ram_we;
    logic           ram_re;
    dkeq_pkg::t_rec ram_wdata;
    dkeq_pkg::t_rec ram_rdata;
    logic [REC_W-1:0] ram_rdata_raw;
    dkeq_pkg::t_rsp rsp;

    // The ring of records lives in one RAM, written on a push and read on a pop.
    dkeq_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = dkeq_pkg::t_rec'(ram_rdata_raw);

    // Handshakes. Items are taken one at a time, so a push and a later pop never overlap.
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Next-state logic for all operations.
    always_comb begin
        n_state     = r_state;
        n_clock     = r_clock;
        n_last_raw  = r_last_raw;
        n_left      = r_left;
        n_armed     = r_armed;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_seq       = r_seq;
        n_led       = r_led;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata.level = r_last_raw;
        ram_wdata.seq   = r_seq + dkeq_pkg::SEQ_W'(1);
        ram_wdata.stamp = r_clock + dkeq_pkg::TIME_W'(1);
        rsp         = '0;

        if (accept) begin
            unique case (dkeq_pkg::t_opcode'(i_req.opcode))
                dkeq_pkg::OP_TICK: begin
                    n_clock = r_clock + dkeq_pkg::TIME_W'(1);
                    if (i_req.key_level != r_last_raw) begin
                        n_last_raw = i_req.key_level;
                        n_left     = r_deb_cfg;
                        n_armed    = 1'b1;
                    end else if (r_armed) begin
                        if (r_left <= dkeq_pkg::DEB_W'(1)) begin
                            // Countdown expired: queue the stable level, dropping the oldest if full.
                            if (next_idx(r_wr_idx) == r_rd_idx) begin
                                n_rd_idx = next_idx(r_rd_idx);
                            end
                            n_seq            = r_seq + dkeq_pkg::SEQ_W'(1);
                            ram_we           = 1'b1;
                            n_wr_idx         = next_idx(r_wr_idx);
                            n_left           = '0;
                            n_armed          = 1'b0;
                            rsp.event_pushed = 1'b1;
                        end else begin
                            n_left = r_left - dkeq_pkg::DEB_W'(1);
                        end
                    end
                end
                dkeq_pkg::OP_READ: begin
                    if (r_rd_idx == r_wr_idx) begin
                        rsp.status = dkeq_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        n_rd_idx = next_idx(r_rd_idx);
                        n_state  = S_READ;
                    end
                end
                dkeq_pkg::OP_SET_LED: begin
                    if (i_req.led_request > dkeq_pkg::LED_W'(1)) begin
                        rsp.status = dkeq_pkg::ST_BAD_LED;
                    end else begin
                        n_led = i_req.led_request[0];
                    end
                end
                dkeq_pkg::OP_GET_LED: begin
                    rsp.status = dkeq_pkg::ST_OK;
                end
                default: begin
                    rsp.status = dkeq_pkg::ST_OK;
                end
            endcase
            rsp.nonempty  = (n_rd_idx != n_wr_idx);
            rsp.led_level = n_led;
            if (n_state == S_IDLE) begin
                n_out       = rsp;
                n_out_valid = 1'b1;
            end
        end else if ((r_state == S_READ) && out_free) begin
            // The popped record is on the RAM read port now.
            n_out.status       = dkeq_pkg::ST_OK;
            n_out.nonempty     = (r_rd_idx != r_wr_idx);
            n_out.event_pushed = 1'b0;
            n_out.rec_level    = ram_rdata.level;
            n_out.rec_sequence = ram_rdata.seq;
            n_out.rec_time     = ram_rdata.stamp;
            n_out.led_level    = r_led;
            n_out_valid        = 1'b1;
            n_state            = S_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deb_cfg   <= dkeq_pkg::DEBOUNCE_RESET;
            r_clock     <= '0;
            r_last_raw  <= 1'b0;
            r_left      <= '0;
            r_armed     <= 1'b0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_seq       <= '0;
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clock     <= n_clock;
            r_last_raw  <= n_last_raw;
            r_left      <= n_left;
            r_armed     <= n_armed;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_seq       <= n_seq;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_deb_cfg <= i_cfg.data;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.nonempty     = r_out.nonempty;
    assign o_rsp.event_pushed = r_out.event_pushed;
    assign o_rsp.rec_level    = r_out.rec_level;
    assign o_rsp.rec_sequence = r_out.rec_sequence;
    assign o_rsp.rec_time     = r_out.rec_time;
    assign o_rsp.led_level    = r_out.led_level;

    // No new item is taken while a ring read is outstanding.
    `DKEQ_ASSERT_IMP(a_read_interlock, i_clk, i_rst_n, r_state == S_READ, !i_req.ready, "item accepted during ring read")
    // A pushed record always leaves the queue non-empty.
    `DKEQ_ASSERT_IMP(a_push_nonempty, i_clk, i_rst_n, r_out_valid && r_out.event_pushed, r_out.nonempty, "push reported empty queue")
    // An empty read reports an empty queue.
    `DKEQ_ASSERT_IMP(a_empty_read, i_clk, i_rst_n, r_out_valid && (r_out.status == dkeq_pkg::ST_EMPTY), !r_out.nonempty, "empty read with data")
    // The countdown is idle at zero whenever it is disarmed.
    `DKEQ_ASSERT_IMP(a_disarmed_zero, i_clk, i_rst_n, !r_armed, r_left == '0, "disarmed countdown not zero")
    // A read of a non-empty queue goes to the read state in the next cycle.
    `DKEQ_ASSERT_NXT(a_read_starts, i_clk, i_rst_n, accept && (i_req.opcode == dkeq_pkg::OP_READ) && (r_rd_idx != r_wr_idx), r_state == S_READ, "ring read not started")

endmodule
